// ----- rtl/lrrf_pkg.sv -----
// lrrf_pkg: shared constants, register and mode codes, sine table generator
// for the lidar ray region filter; no dependencies
`default_nettype none

package lrrf_pkg;

    // field widths fixed by the register map and the result word
    localparam int RADIUS_BITS    = 16;
    localparam int BOX_BITS       = 18;
    localparam int STEP_BITS      = 16;
    localparam int MODE_BITS      = 2;
    localparam int OUT_RANGE_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;

    // sine table format: unsigned magnitude in Q0.15, 0..32767
    localparam int SINE_BITS = 15;
    localparam int SINE_FRAC = 15;
    localparam longint SINE_MAX    = 64'sd32767;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q15_ONE     = 64'sd32768;
    localparam longint Q15_HALF    = 64'sd16384;
    localparam int SERIES_TERMS    = 10;
    localparam longint SERIES_DIV [SERIES_TERMS] =
        '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
          64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420};

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RADIUS_LOW,
        CFG_RADIUS_HIGH,
        CFG_BOX_X_LOW,
        CFG_BOX_X_HIGH,
        CFG_BOX_Y_LOW,
        CFG_BOX_Y_HIGH,
        CFG_COMBINE_MODE,
        CFG_ANGLE_STEP
    } cfg_index_t;

    // how the box and radius tests are combined
    typedef enum logic [MODE_BITS-1:0] {
        MODE_UNION,
        MODE_INTERSECT,
        MODE_PASS
    } combine_mode_t;

    // register reset values
    localparam logic [RADIUS_BITS-1:0]     RADIUS_LOW_RST  = '0;
    localparam logic [RADIUS_BITS-1:0]     RADIUS_HIGH_RST = '1;
    localparam logic signed [BOX_BITS-1:0] BOX_LOW_RST     = {1'b1, {(BOX_BITS-1){1'b0}}};
    localparam logic signed [BOX_BITS-1:0] BOX_HIGH_RST    = {1'b0, {(BOX_BITS-1){1'b1}}};

    // sin of a Q2.30 angle by truncated power series, rounded to Q0.15;
    // evaluated only on constants while building the table
    function automatic logic [SINE_BITS-1:0] sine_q15(input longint x);
        longint term;
        longint sum;
        term = x;
        sum  = x;
        for (int n = 0; n < SERIES_TERMS; n++)
        begin
            term = term * x / Q30_ONE;
            term = term * x / Q30_ONE;
            term = -term / SERIES_DIV[n];
            sum  = sum + term;
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + Q15_HALF) / Q15_ONE;
        if (sum > SINE_MAX)
        begin
            sum = SINE_MAX;
        end
        return SINE_BITS'(sum);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lrrf_if.sv -----
// lrrf_if: valid/ready channels of the lidar ray region filter
// (ray input, filtered ray output, register write); depends on lrrf_pkg
`default_nettype none

// one lidar ray per word
interface lrrf_ray_in_if #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic                  first_ray;
    logic [ANGLE_BITS-1:0] start_angle;
    logic                  last_ray;

    modport source (output valid, range_mm, first_ray, start_angle, last_ray, input ready);
    modport sink   (input valid, range_mm, first_ray, start_angle, last_ray, output ready);
endinterface

// one filtered ray per word
interface lrrf_ray_out_if import lrrf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OUT_RANGE_BITS-1:0] range_out;
    logic                      kept;
    logic                      last_out;

    modport source (output valid, range_out, kept, last_out, input ready);
    modport sink   (input valid, range_out, kept, last_out, output ready);
endinterface

// register write channel
interface lrrf_cfg_if import lrrf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lidar_ray_region_filter_unit.sv -----
// lidar_ray_region_filter_unit: five-stage ray pipeline (angle and table
// address, sine lookup, multiply, rounding, region test and output word).
// Accepts one ray per cycle while the output is not stalled; each ray word
// passes stages 1 to 4 and the output register; stages move independently so bubbles close up under backpressure.
// The sine and cosine lookups each read the constant quarter-wave table once.
// Reset: registers go to their defaults, ray angle 0, pipeline empty.
`default_nettype none

module lidar_ray_region_filter_unit import lrrf_pkg::*; #(
    parameter int RANGE_BITS       = 16,
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    lrrf_ray_in_if.sink    ray_in,
    lrrf_ray_out_if.source ray_out,
    lrrf_cfg_if.sink       cfg
);

    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int ADDR_BITS    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDX_PROD     = QUARTER_BITS + ADDR_BITS;
    localparam int TRIG_BITS    = SINE_BITS + 1;
    localparam int PROD_BITS    = RANGE_BITS + 1 + TRIG_BITS;
    localparam int COORD_BITS   = RANGE_BITS + 1;
    localparam int CMP_BITS     = (COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS;
    localparam int RCMP_BITS    = (RANGE_BITS > RADIUS_BITS) ? RANGE_BITS : RADIUS_BITS;
    localparam logic [IDX_PROD-1:0]  DEPTH_W   = IDX_PROD'(SINE_TABLE_DEPTH);
    localparam logic [ADDR_BITS-1:0] DEPTH_A   = ADDR_BITS'(SINE_TABLE_DEPTH);
    localparam logic [PROD_BITS-1:0] ROUND_ADD = PROD_BITS'(1) << (SINE_FRAC - 1);

    // quarter-wave sine table, entry DEPTH is a full quarter
    logic [SINE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        localparam longint ANGLE_Q30 = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
        if (k == SINE_TABLE_DEPTH)
        begin : g_full
            assign sine_rom[k] = SINE_BITS'(SINE_MAX);
        end
        else
        begin : g_entry
            assign sine_rom[k] = sine_q15(ANGLE_Q30);
        end
    end

    // configuration registers
    logic [RADIUS_BITS-1:0]     radius_low_reg;
    logic [RADIUS_BITS-1:0]     radius_high_reg;
    logic signed [BOX_BITS-1:0] box_x_low_reg;
    logic signed [BOX_BITS-1:0] box_x_high_reg;
    logic signed [BOX_BITS-1:0] box_y_low_reg;
    logic signed [BOX_BITS-1:0] box_y_high_reg;
    logic [MODE_BITS-1:0]       combine_mode_reg;
    logic [STEP_BITS-1:0]       angle_step_reg;
    logic                       cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_low_reg   <= RADIUS_LOW_RST;
            radius_high_reg  <= RADIUS_HIGH_RST;
            box_x_low_reg    <= BOX_LOW_RST;
            box_x_high_reg   <= BOX_HIGH_RST;
            box_y_low_reg    <= BOX_LOW_RST;
            box_y_high_reg   <= BOX_HIGH_RST;
            combine_mode_reg <= MODE_UNION;
            angle_step_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg.reg_index)
                CFG_RADIUS_LOW:   radius_low_reg   <= RADIUS_BITS'(cfg.wr_data);
                CFG_RADIUS_HIGH:  radius_high_reg  <= RADIUS_BITS'(cfg.wr_data);
                CFG_BOX_X_LOW:    box_x_low_reg    <= BOX_BITS'(cfg.wr_data);
                CFG_BOX_X_HIGH:   box_x_high_reg   <= BOX_BITS'(cfg.wr_data);
                CFG_BOX_Y_LOW:    box_y_low_reg    <= BOX_BITS'(cfg.wr_data);
                CFG_BOX_Y_HIGH:   box_y_high_reg   <= BOX_BITS'(cfg.wr_data);
                CFG_COMBINE_MODE: combine_mode_reg <= MODE_BITS'(cfg.wr_data);
                CFG_ANGLE_STEP:   angle_step_reg   <= STEP_BITS'(cfg.wr_data);
                default:          ;
            endcase
        end
    end

    // stage valids and advance chain, output side first
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic out_adv, s4_adv, s3_adv, s2_adv, s1_adv, in_acc;

    assign out_adv      = !out_valid_reg || ray_out.ready;
    assign s4_adv       = !s4_valid_reg || out_adv;
    assign s3_adv       = !s3_valid_reg || s4_adv;
    assign s2_adv       = !s2_valid_reg || s3_adv;
    assign s1_adv       = !s1_valid_reg || s2_adv;
    assign ray_in.ready = s1_adv;
    assign in_acc       = ray_in.valid && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= ray_in.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // running ray angle: loaded on the first ray, stepped after every ray
    logic [ANGLE_BITS-1:0] ray_angle_reg;
    logic [ANGLE_BITS-1:0] ray_angle_next;
    logic [ANGLE_BITS-1:0] cur_angle;

    assign cur_angle      = ray_in.first_ray ? ray_in.start_angle : ray_angle_reg;
    assign ray_angle_next = cur_angle + ANGLE_BITS'(angle_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_angle_reg <= '0;
        end
        else if (in_acc)
        begin
            ray_angle_reg <= ray_angle_next;
        end
    end

    // table address and sign for sine and cosine (cosine is one quadrant on)
    logic [1:0]              quad;
    logic [1:0]              cos_quad;
    logic [IDX_PROD-1:0]     idx_prod;
    logic [ADDR_BITS-1:0]    idx;
    logic [ADDR_BITS-1:0]    idx_mirror;

    assign quad       = cur_angle[ANGLE_BITS-1 -: 2];
    assign cos_quad   = quad + 2'd1;
    assign idx_prod   = IDX_PROD'(cur_angle[QUARTER_BITS-1:0]) * DEPTH_W;
    assign idx        = idx_prod[QUARTER_BITS +: ADDR_BITS];
    assign idx_mirror = DEPTH_A - idx;

    // stage 1: ray word and table addresses
    logic [RANGE_BITS-1:0] s1_range_reg;
    logic                  s1_last_reg;
    logic [ADDR_BITS-1:0]  s1_sin_addr_reg;
    logic [ADDR_BITS-1:0]  s1_cos_addr_reg;
    logic                  s1_sin_neg_reg;
    logic                  s1_cos_neg_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_range_reg    <= ray_in.range_mm;
            s1_last_reg     <= ray_in.last_ray;
            s1_sin_addr_reg <= quad[0] ? idx_mirror : idx;
            s1_cos_addr_reg <= cos_quad[0] ? idx_mirror : idx;
            s1_sin_neg_reg  <= quad[1];
            s1_cos_neg_reg  <= cos_quad[1];
        end
    end

    // stage 2: signed sine and cosine from the table
    logic [RANGE_BITS-1:0]       s2_range_reg;
    logic                        s2_last_reg;
    logic signed [TRIG_BITS-1:0] s2_sin_reg;
    logic signed [TRIG_BITS-1:0] s2_cos_reg;
    logic signed [TRIG_BITS-1:0] sin_mag;
    logic signed [TRIG_BITS-1:0] cos_mag;

    assign sin_mag = signed'({1'b0, sine_rom[s1_sin_addr_reg]});
    assign cos_mag = signed'({1'b0, sine_rom[s1_cos_addr_reg]});

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_range_reg <= s1_range_reg;
            s2_last_reg  <= s1_last_reg;
            s2_sin_reg   <= s1_sin_neg_reg ? -sin_mag : sin_mag;
            s2_cos_reg   <= s1_cos_neg_reg ? -cos_mag : cos_mag;
        end
    end

    // stage 3: range times cosine and sine
    logic [RANGE_BITS-1:0]       s3_range_reg;
    logic                        s3_last_reg;
    logic signed [PROD_BITS-1:0] s3_px_reg;
    logic signed [PROD_BITS-1:0] s3_py_reg;
    logic signed [RANGE_BITS:0]  range_s;

    assign range_s = signed'({1'b0, s2_range_reg});

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_range_reg <= s2_range_reg;
            s3_last_reg  <= s2_last_reg;
            s3_px_reg    <= range_s * s2_cos_reg;
            s3_py_reg    <= range_s * s2_sin_reg;
        end
    end

    // round a Q15 product to millimetres, half away from zero
    function automatic logic signed [COORD_BITS-1:0] round_q15(
        input logic signed [PROD_BITS-1:0] p
    );
        logic [PROD_BITS-1:0]  mag;
        logic [PROD_BITS-1:0]  sum;
        logic [COORD_BITS-1:0] r;
        mag = p[PROD_BITS-1] ? PROD_BITS'(-p) : PROD_BITS'(p);
        sum = mag + ROUND_ADD;
        r   = COORD_BITS'(sum[PROD_BITS-1:SINE_FRAC]);
        return p[PROD_BITS-1] ? signed'(-r) : signed'(r);
    endfunction

    // stage 4: x and y in millimetres
    logic [RANGE_BITS-1:0]        s4_range_reg;
    logic                         s4_last_reg;
    logic signed [COORD_BITS-1:0] s4_x_reg;
    logic signed [COORD_BITS-1:0] s4_y_reg;

    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            s4_range_reg <= s3_range_reg;
            s4_last_reg  <= s3_last_reg;
            s4_x_reg     <= round_q15(s3_px_reg);
            s4_y_reg     <= round_q15(s3_py_reg);
        end
    end

    // region tests and combine
    logic signed [CMP_BITS-1:0] x_c;
    logic signed [CMP_BITS-1:0] y_c;
    logic [RCMP_BITS-1:0]       range_c;
    logic                       in_box;
    logic                       in_band;
    logic                       keep;
    logic [RANGE_BITS-1:0]      range_sel;

    assign x_c     = CMP_BITS'(s4_x_reg);
    assign y_c     = CMP_BITS'(s4_y_reg);
    assign range_c = RCMP_BITS'(s4_range_reg);
    assign in_box  = (CMP_BITS'(box_x_low_reg) <= x_c) && (x_c <= CMP_BITS'(box_x_high_reg))
                  && (CMP_BITS'(box_y_low_reg) <= y_c) && (y_c <= CMP_BITS'(box_y_high_reg));
    assign in_band = (RCMP_BITS'(radius_low_reg) <= range_c)
                  && (range_c <= RCMP_BITS'(radius_high_reg));

    always_comb
    begin
        case (combine_mode_reg)
            MODE_UNION:     keep = in_box || in_band;
            MODE_INTERSECT: keep = in_box && in_band;
            MODE_PASS:      keep = 1'b1;
            default:        keep = 1'b1;
        endcase
    end

    assign range_sel = keep ? s4_range_reg : '1;

    // output word register
    logic [OUT_RANGE_BITS-1:0] out_range_reg;
    logic                      out_kept_reg;
    logic                      out_last_reg;

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_range_reg <= OUT_RANGE_BITS'(range_sel);
            out_kept_reg  <= keep;
            out_last_reg  <= s4_last_reg;
        end
    end

    assign ray_out.valid     = out_valid_reg;
    assign ray_out.range_out = out_range_reg;
    assign ray_out.kept      = out_kept_reg;
    assign ray_out.last_out  = out_last_reg;

endmodule

`default_nettype wire
